// File: hdl/mntg_pkg.sv
// Shared constants, opcodes, handshake structs and saturating adders for the mesh normal block.
`timescale 1ns / 1ps
`default_nettype none
package mntg_pkg;

	localparam int VIDX_W   = 10;
	localparam int FIDX_W   = 11;
	localparam int VCNT_W   = VIDX_W + 1;
	localparam int FCNT_W   = FIDX_W + 1;
	localparam int MAX_VERTICES = 1 << VIDX_W;
	localparam int MAX_FACES    = 1 << FIDX_W;
	localparam int COORD_W  = 16;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int VEC_W    = 36;
	localparam int NRM_W    = 16;
	localparam int NSUM_W   = 20;
	localparam int TSUM_W   = 21;
	localparam int DIVD_W   = 48;
	localparam int DVSR_W   = 36;
	localparam int QUO_W    = 21;
	localparam int NBITS_W  = 5;
	localparam int LEN_W    = 32;
	localparam int SQ_W     = 64;
	localparam int RED_W    = 30;
	localparam int UNIT_SHIFT = 14;
	localparam int TAN_FRAC   = 12;
	localparam int TAN_OVF    = 9;

	localparam logic [NBITS_W-1:0] NORM_QBITS = NBITS_W'(15);
	localparam logic [NBITS_W-1:0] TAN_QBITS  = NBITS_W'(QUO_W);
	localparam logic [TSUM_W-1:0]  TAN_SAT    = {1'b0, {(TSUM_W-1){1'b1}}};

	localparam logic [2:0] OP_LOAD_VERTEX = 3'd0;
	localparam logic [2:0] OP_LOAD_FACE   = 3'd1;
	localparam logic [2:0] OP_COMPUTE     = 3'd2;
	localparam logic [2:0] OP_READ        = 3'd3;
	localparam logic [2:0] OP_CLEAR       = 3'd4;

	typedef struct packed {
		logic                     start;
		logic signed [VEC_W-1:0]  x;
		logic signed [VEC_W-1:0]  y;
		logic signed [VEC_W-1:0]  z;
	} norm_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [NRM_W-1:0]  x;
		logic signed [NRM_W-1:0]  y;
		logic signed [NRM_W-1:0]  z;
	} norm_rsp_t;

	typedef struct packed {
		logic                     start;
		logic [DIVD_W-1:0]        dividend;
		logic [DVSR_W-1:0]        divisor;
		logic [NBITS_W-1:0]       nbits;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic [QUO_W-1:0]         quotient;
	} div_rsp_t;

	function automatic logic [VEC_W-1:0] mag_v(input logic signed [VEC_W-1:0] x);
		return x[VEC_W-1] ? VEC_W'(-x) : VEC_W'(x);
	endfunction

	function automatic logic signed [NSUM_W-1:0] nsum_add(input logic signed [NSUM_W-1:0] s,
		input logic signed [NRM_W-1:0] d);
		logic signed [NSUM_W:0] t;
		t = (NSUM_W+1)'(s) + (NSUM_W+1)'(d);
		if (t[NSUM_W] != t[NSUM_W-1])
			return t[NSUM_W] ? {1'b1, {(NSUM_W-1){1'b0}}} : {1'b0, {(NSUM_W-1){1'b1}}};
		return t[NSUM_W-1:0];
	endfunction

	function automatic logic signed [TSUM_W-1:0] tsum_add(input logic signed [TSUM_W-1:0] s,
		input logic signed [TSUM_W-1:0] d);
		logic signed [TSUM_W:0] t;
		t = (TSUM_W+1)'(s) + (TSUM_W+1)'(d);
		if (t[TSUM_W] != t[TSUM_W-1])
			return t[TSUM_W] ? {1'b1, {(TSUM_W-1){1'b0}}} : {1'b0, {(TSUM_W-1){1'b1}}};
		return t[TSUM_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: hdl/mesh_normal_tangent_generator_core.sv
// Top level: command decoder, mesh memories and the face/vertex sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Smooth vertex normal and tangent generator.
// One command channel: an item is taken at a clock edge with start high and busy low.
// Opcodes: load vertex, load face, compute, read vertex, clear mesh.
// Loads leave busy low; a read of an unloaded vertex answers
// in the next cycle with status 1.
// A read of a loaded vertex normalizes two sums through the shared normalizer,
// using its 32-step square root and three 15-step divides.
// Results come on done for exactly one cycle; the receiver cannot hold them off.
// Compute first sweeps both sum memories (one entry a cycle), then walks
// the faces: face fetch, three vertex fetches, seven products on one
// multiply pair, normalize, up to three 21-step tangent divides, and three
// read-modify-write passes on the sum memories.
// Corner updates are strictly serialized, so a face that repeats a vertex sees
// its own earlier write.
// Clear resets both counts and runs the same sweep.
// After reset the block sweeps the sum memories once (busy high during the sweep).
// Vertex, texcoord and face memories are never cleared; only loaded entries are read.
module mesh_normal_tangent_generator_core import mntg_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output      logic                      busy,
	input  wire logic [2:0]                opcode,
	input  wire logic signed [COORD_W-1:0] pos_x,
	input  wire logic signed [COORD_W-1:0] pos_y,
	input  wire logic signed [COORD_W-1:0] pos_z,
	input  wire logic signed [COORD_W-1:0] tex_u,
	input  wire logic signed [COORD_W-1:0] tex_v,
	input  wire logic [VIDX_W-1:0]         corner_a,
	input  wire logic [VIDX_W-1:0]         corner_b,
	input  wire logic [VIDX_W-1:0]         corner_c,
	input  wire logic [VIDX_W-1:0]         vertex_select,
	output      logic                      done,
	output      logic [VIDX_W-1:0]         vertex_index,
	output      logic signed [NRM_W-1:0]   normal_x,
	output      logic signed [NRM_W-1:0]   normal_y,
	output      logic signed [NRM_W-1:0]   normal_z,
	output      logic signed [NRM_W-1:0]   tangent_x,
	output      logic signed [NRM_W-1:0]   tangent_y,
	output      logic signed [NRM_W-1:0]   tangent_z,
	output      logic                      status
);

	localparam logic [4:0] S_CLR       = 5'd0;
	localparam logic [4:0] S_IDLE      = 5'd1;
	localparam logic [4:0] S_FACE_RD   = 5'd2;
	localparam logic [4:0] S_FACE_CHK  = 5'd3;
	localparam logic [4:0] S_VRD       = 5'd4;
	localparam logic [4:0] S_EDGE      = 5'd5;
	localparam logic [4:0] S_MUL       = 5'd6;
	localparam logic [4:0] S_NORM_GO   = 5'd7;
	localparam logic [4:0] S_NORM_WAIT = 5'd8;
	localparam logic [4:0] S_TAN       = 5'd9;
	localparam logic [4:0] S_TDIV_WAIT = 5'd10;
	localparam logic [4:0] S_ACC_RD    = 5'd11;
	localparam logic [4:0] S_ACC_WR    = 5'd12;
	localparam logic [4:0] S_NEXT      = 5'd13;
	localparam logic [4:0] S_RD_N      = 5'd14;
	localparam logic [4:0] S_RD_NW     = 5'd15;
	localparam logic [4:0] S_RD_T      = 5'd16;
	localparam logic [4:0] S_RD_TW     = 5'd17;

	localparam int POS_W  = 3 * COORD_W;
	localparam int TEX_W  = 2 * COORD_W;
	localparam int FACE_W = 3 * VIDX_W;
	localparam int NS_W   = 3 * NSUM_W;
	localparam int TS_W   = 3 * TSUM_W;
	localparam int OVF_W  = DVSR_W + TAN_OVF;

	// control
	logic [4:0]          state_q;
	logic [VCNT_W-1:0]   vcount_q;
	logic [FCNT_W-1:0]   fcount_q;
	logic [VIDX_W-1:0]   sweep_q;
	logic                cmp_pend_q;
	logic                done_q;
	logic [FCNT_W-1:0]   f_q;
	logic [1:0]          j_q;
	logic [2:0]          k_q;
	logic [1:0]          t_q;
	logic [1:0]          c_q;

	// datapath
	logic [VIDX_W-1:0]          corner_q [3];
	logic signed [COORD_W-1:0]  pos_q [3][3];
	logic signed [COORD_W-1:0]  tex_q [3][2];
	logic signed [DIFF_W-1:0]   e1_q [3];
	logic signed [DIFF_W-1:0]   e2_q [3];
	logic signed [DIFF_W-1:0]   du1_q, du2_q, dv1_q, dv2_q;
	logic signed [VEC_W-1:0]    prod_q [7];
	logic signed [NRM_W-1:0]    nf_q [3];
	logic signed [TSUM_W-1:0]   tf_q [3];
	logic [VIDX_W-1:0]          sel_q;
	logic [TS_W-1:0]            thold_q;
	logic signed [NRM_W-1:0]    nn_q [3];
	logic [VIDX_W-1:0]          idx_q;
	logic signed [NRM_W-1:0]    onrm_q [3];
	logic signed [NRM_W-1:0]    otan_q [3];
	logic                       status_q;

	// memories
	logic                accept;
	logic                pos_we, face_we, sum_we;
	logic [VIDX_W-1:0]   vaddr;
	logic [POS_W-1:0]    pos_rd;
	logic [TEX_W-1:0]    tex_rd;
	logic [FACE_W-1:0]   face_rd;
	logic [VIDX_W-1:0]   sum_raddr, sum_waddr;
	logic [NS_W-1:0]     ns_rd, ns_wd;
	logic [TS_W-1:0]     ts_rd, ts_wd;

	// arithmetic
	logic signed [DIFF_W-1:0] op_a, op_b, op_c, op_d;
	logic signed [PROD_W-1:0] p_ab, p_cd;
	logic signed [VEC_W-1:0]  mul_res;
	logic signed [VEC_W-1:0]  num_sel, det;
	logic [VEC_W-1:0]         an, ad;
	logic                     tneg, tsat;
	logic [TSUM_W-1:0]        tq;
	logic [VIDX_W-1:0]        fc [3];
	logic                     face_bad;
	logic                     sel_bad;
	norm_req_t                nreq;
	norm_rsp_t                nrsp;
	div_req_t                 treq;
	div_rsp_t                 trsp;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign pos_we  = accept && (opcode == OP_LOAD_VERTEX) && !vcount_q[VCNT_W-1];
	assign face_we = accept && (opcode == OP_LOAD_FACE) && !fcount_q[FCNT_W-1];

	always_comb begin
		unique case (j_q)
			2'd0:    vaddr = corner_q[0];
			2'd1:    vaddr = corner_q[1];
			default: vaddr = corner_q[2];
		endcase
	end

	mntg_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(vcount_q[VIDX_W-1:0]),
		.wdata({pos_z, pos_y, pos_x}), .raddr(vaddr), .rdata(pos_rd));

	mntg_ram #(.WIDTH(TEX_W), .DEPTH(MAX_VERTICES)) u_tex_ram (
		.clk(clk), .we(pos_we), .waddr(vcount_q[VIDX_W-1:0]),
		.wdata({tex_v, tex_u}), .raddr(vaddr), .rdata(tex_rd));

	mntg_ram #(.WIDTH(FACE_W), .DEPTH(MAX_FACES)) u_face_ram (
		.clk(clk), .we(face_we), .waddr(fcount_q[FIDX_W-1:0]),
		.wdata({corner_c, corner_b, corner_a}), .raddr(f_q[FIDX_W-1:0]), .rdata(face_rd));

	// Sum memories: swept to zero in S_CLR, otherwise written by corner updates.
	assign sum_we    = (state_q == S_CLR) || (state_q == S_ACC_WR);
	assign sum_waddr = (state_q == S_CLR) ? sweep_q : corner_q[c_q];
	assign sum_raddr = (state_q == S_IDLE) ? vertex_select : corner_q[c_q];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ns_wd[i*NSUM_W +: NSUM_W] = nsum_add(ns_rd[i*NSUM_W +: NSUM_W], nf_q[i]);
			ts_wd[i*TSUM_W +: TSUM_W] = tsum_add(ts_rd[i*TSUM_W +: TSUM_W], tf_q[i]);
		end
		if (state_q == S_CLR) begin
			ns_wd = '0;
			ts_wd = '0;
		end
	end

	mntg_ram #(.WIDTH(NS_W), .DEPTH(MAX_VERTICES)) u_nsum_ram (
		.clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(ns_wd),
		.raddr(sum_raddr), .rdata(ns_rd));

	mntg_ram #(.WIDTH(TS_W), .DEPTH(MAX_VERTICES)) u_tsum_ram (
		.clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(ts_wd),
		.raddr(sum_raddr), .rdata(ts_rd));

	// Face decode and skip check
	assign fc[0] = face_rd[0*VIDX_W +: VIDX_W];
	assign fc[1] = face_rd[1*VIDX_W +: VIDX_W];
	assign fc[2] = face_rd[2*VIDX_W +: VIDX_W];
	assign face_bad = ({1'b0, fc[0]} >= vcount_q) || ({1'b0, fc[1]} >= vcount_q)
		|| ({1'b0, fc[2]} >= vcount_q);
	assign sel_bad  = ({1'b0, vertex_select} >= vcount_q);

	// One multiply pair: cross product, UV determinant, tangent numerators.
	always_comb begin
		unique case (k_q)
			3'd0: begin op_a = e1_q[1]; op_b = e2_q[2]; op_c = e1_q[2]; op_d = e2_q[1]; end
			3'd1: begin op_a = e1_q[2]; op_b = e2_q[0]; op_c = e1_q[0]; op_d = e2_q[2]; end
			3'd2: begin op_a = e1_q[0]; op_b = e2_q[1]; op_c = e1_q[1]; op_d = e2_q[0]; end
			3'd3: begin op_a = du1_q;   op_b = dv2_q;   op_c = du2_q;   op_d = dv1_q;   end
			3'd4: begin op_a = dv2_q;   op_b = e1_q[0]; op_c = dv1_q;   op_d = e2_q[0]; end
			3'd5: begin op_a = dv2_q;   op_b = e1_q[1]; op_c = dv1_q;   op_d = e2_q[1]; end
			default: begin op_a = dv2_q; op_b = e1_q[2]; op_c = dv1_q; op_d = e2_q[2]; end
		endcase
	end

	assign p_ab    = op_a * op_b;
	assign p_cd    = op_c * op_d;
	assign mul_res = VEC_W'(p_ab) - VEC_W'(p_cd);

	// Tangent component: numerator / det in Q.12, saturated
	always_comb begin
		unique case (t_q)
			2'd0:    num_sel = prod_q[4];
			2'd1:    num_sel = prod_q[5];
			default: num_sel = prod_q[6];
		endcase
	end

	assign det  = prod_q[3];
	assign an   = mag_v(num_sel);
	assign ad   = mag_v(det);
	assign tneg = num_sel[VEC_W-1] ^ det[VEC_W-1];
	assign tsat = OVF_W'(an) >= (OVF_W'(ad) << TAN_OVF);
	assign tq   = trsp.quotient[QUO_W-1] ? TAN_SAT : trsp.quotient;

	assign treq.start    = (state_q == S_TAN) && (det != '0) && !tsat;
	assign treq.dividend = DIVD_W'(an) << TAN_FRAC;
	assign treq.divisor  = DVSR_W'(ad);
	assign treq.nbits    = TAN_QBITS;

	mntg_div u_tdiv (.clk(clk), .arst_n(arst_n), .req(treq), .rsp(trsp));

	// Shared normalizer: face cross product, or a vertex's two sums on a read.
	always_comb begin
		nreq.start = (state_q == S_NORM_GO) || (state_q == S_RD_N) || (state_q == S_RD_T);
		unique case (state_q)
			S_RD_N: begin
				nreq.x = VEC_W'($signed(ns_rd[0*NSUM_W +: NSUM_W]));
				nreq.y = VEC_W'($signed(ns_rd[1*NSUM_W +: NSUM_W]));
				nreq.z = VEC_W'($signed(ns_rd[2*NSUM_W +: NSUM_W]));
			end
			S_RD_T: begin
				nreq.x = VEC_W'($signed(thold_q[0*TSUM_W +: TSUM_W]));
				nreq.y = VEC_W'($signed(thold_q[1*TSUM_W +: TSUM_W]));
				nreq.z = VEC_W'($signed(thold_q[2*TSUM_W +: TSUM_W]));
			end
			default: begin
				nreq.x = prod_q[0];
				nreq.y = prod_q[1];
				nreq.z = prod_q[2];
			end
		endcase
	end

	mntg_norm u_norm (.clk(clk), .arst_n(arst_n), .req(nreq), .rsp(nrsp));

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			vcount_q   <= '0;
			fcount_q   <= '0;
			sweep_q    <= '0;
			cmp_pend_q <= 1'b0;
			done_q     <= 1'b0;
			f_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			t_q        <= '0;
			c_q        <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					sweep_q <= sweep_q + VIDX_W'(1);
					if (&sweep_q) begin
						cmp_pend_q <= 1'b0;
						f_q        <= '0;
						if (cmp_pend_q && (fcount_q != '0))
							state_q <= S_FACE_RD;
						else
							state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (opcode)
							OP_LOAD_VERTEX: begin
								if (pos_we) vcount_q <= vcount_q + VCNT_W'(1);
							end
							OP_LOAD_FACE: begin
								if (face_we) fcount_q <= fcount_q + FCNT_W'(1);
							end
							OP_COMPUTE: begin
								sweep_q    <= '0;
								cmp_pend_q <= 1'b1;
								state_q    <= S_CLR;
							end
							OP_READ: begin
								if (sel_bad)
									done_q <= 1'b1;
								else
									state_q <= S_RD_N;
							end
							OP_CLEAR: begin
								vcount_q   <= '0;
								fcount_q   <= '0;
								sweep_q    <= '0;
								cmp_pend_q <= 1'b0;
								state_q    <= S_CLR;
							end
							default: ;
						endcase
					end
				end
				S_FACE_RD: state_q <= S_FACE_CHK;
				S_FACE_CHK: begin
					j_q     <= '0;
					state_q <= face_bad ? S_NEXT : S_VRD;
				end
				S_VRD: begin
					j_q <= j_q + 2'd1;
					if (j_q == 2'd3) state_q <= S_EDGE;
				end
				S_EDGE: begin
					k_q     <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd6) state_q <= S_NORM_GO;
				end
				S_NORM_GO: state_q <= S_NORM_WAIT;
				S_NORM_WAIT: begin
					if (nrsp.done) begin
						t_q     <= '0;
						state_q <= S_TAN;
					end
				end
				S_TAN: begin
					if (det == '0) begin
						c_q     <= '0;
						state_q <= S_ACC_RD;
					end else if (tsat) begin
						if (t_q == 2'd2) begin
							c_q     <= '0;
							state_q <= S_ACC_RD;
						end else begin
							t_q <= t_q + 2'd1;
						end
					end else begin
						state_q <= S_TDIV_WAIT;
					end
				end
				S_TDIV_WAIT: begin
					if (trsp.done) begin
						if (t_q == 2'd2) begin
							c_q     <= '0;
							state_q <= S_ACC_RD;
						end else begin
							t_q     <= t_q + 2'd1;
							state_q <= S_TAN;
						end
					end
				end
				S_ACC_RD: state_q <= S_ACC_WR;
				S_ACC_WR: begin
					if (c_q == 2'd2) begin
						state_q <= S_NEXT;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= S_ACC_RD;
					end
				end
				S_NEXT: begin
					if (f_q + FCNT_W'(1) == fcount_q) begin
						state_q <= S_IDLE;
					end else begin
						f_q     <= f_q + FCNT_W'(1);
						state_q <= S_FACE_RD;
					end
				end
				S_RD_N: state_q <= S_RD_NW;
				S_RD_NW: begin
					if (nrsp.done) state_q <= S_RD_T;
				end
				S_RD_T: state_q <= S_RD_TW;
				S_RD_TW: begin
					if (nrsp.done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept && (opcode == OP_READ)) begin
					sel_q <= vertex_select;
					if (sel_bad) begin
						idx_q    <= vertex_select;
						status_q <= 1'b1;
						for (int i = 0; i < 3; i++) begin
							onrm_q[i] <= '0;
							otan_q[i] <= '0;
						end
					end
				end
			end
			S_FACE_CHK: begin
				for (int i = 0; i < 3; i++) corner_q[i] <= fc[i];
			end
			S_VRD: begin
				if (j_q != 2'd0) begin
					for (int i = 0; i < 3; i++)
						pos_q[j_q - 2'd1][i] <= pos_rd[i*COORD_W +: COORD_W];
					tex_q[j_q - 2'd1][0] <= tex_rd[0 +: COORD_W];
					tex_q[j_q - 2'd1][1] <= tex_rd[COORD_W +: COORD_W];
				end
			end
			S_EDGE: begin
				for (int i = 0; i < 3; i++) begin
					e1_q[i] <= DIFF_W'(pos_q[1][i]) - DIFF_W'(pos_q[0][i]);
					e2_q[i] <= DIFF_W'(pos_q[2][i]) - DIFF_W'(pos_q[0][i]);
				end
				du1_q <= DIFF_W'(tex_q[1][0]) - DIFF_W'(tex_q[0][0]);
				du2_q <= DIFF_W'(tex_q[2][0]) - DIFF_W'(tex_q[0][0]);
				dv1_q <= DIFF_W'(tex_q[1][1]) - DIFF_W'(tex_q[0][1]);
				dv2_q <= DIFF_W'(tex_q[2][1]) - DIFF_W'(tex_q[0][1]);
			end
			S_MUL: begin
				prod_q[k_q] <= mul_res;
			end
			S_NORM_WAIT: begin
				if (nrsp.done) begin
					nf_q[0] <= nrsp.x;
					nf_q[1] <= nrsp.y;
					nf_q[2] <= nrsp.z;
				end
			end
			S_TAN: begin
				if (det == '0) begin
					for (int i = 0; i < 3; i++) tf_q[i] <= '0;
				end else if (tsat) begin
					tf_q[t_q] <= tneg ? -TAN_SAT : TAN_SAT;
				end
			end
			S_TDIV_WAIT: begin
				if (trsp.done) tf_q[t_q] <= tneg ? -tq : tq;
			end
			S_RD_N: begin
				thold_q <= ts_rd;
			end
			S_RD_NW: begin
				if (nrsp.done) begin
					nn_q[0] <= nrsp.x;
					nn_q[1] <= nrsp.y;
					nn_q[2] <= nrsp.z;
				end
			end
			S_RD_TW: begin
				if (nrsp.done) begin
					idx_q     <= sel_q;
					status_q  <= 1'b0;
					for (int i = 0; i < 3; i++) onrm_q[i] <= nn_q[i];
					otan_q[0] <= nrsp.x;
					otan_q[1] <= nrsp.y;
					otan_q[2] <= nrsp.z;
				end
			end
			default: ;
		endcase
	end

	assign done         = done_q;
	assign vertex_index = idx_q;
	assign normal_x     = onrm_q[0];
	assign normal_y     = onrm_q[1];
	assign normal_z     = onrm_q[2];
	assign tangent_x    = otan_q[0];
	assign tangent_y    = otan_q[1];
	assign tangent_z    = otan_q[2];
	assign status       = status_q;

endmodule
`default_nettype wire

// File: hdl/mntg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mntg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: hdl/mntg_div.sv
// Restoring divider, one quotient bit per cycle, quotient known to fit nbits.
`timescale 1ns / 1ps
`default_nettype none
module mntg_div import mntg_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire div_req_t req,
	output      div_rsp_t rsp
);

	localparam int DS_W = DVSR_W + QUO_W - 1;

	logic                busy_q;
	logic                done_q;
	logic [NBITS_W-1:0]  cnt_q;
	logic [DIVD_W-1:0]   rem_q;
	logic [DS_W-1:0]     ds_q;
	logic [QUO_W-1:0]    quo_q;
	logic                fits;

	assign fits = DS_W'(rem_q) >= ds_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q && req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - NBITS_W'(1);
				if (cnt_q == NBITS_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && req.start) begin
			rem_q <= req.dividend;
			ds_q  <= DS_W'(req.divisor) << (req.nbits - NBITS_W'(1));
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits)
				rem_q <= rem_q - ds_q[DIVD_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
			ds_q  <= ds_q >> 1;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

// File: hdl/mntg_norm.sv
// Vector normalizer to Q1.14: magnitude, range reduction, squares, bitwise root, divides.
`timescale 1ns / 1ps
`default_nettype none
module mntg_norm import mntg_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire norm_req_t req,
	output      norm_rsp_t rsp
);

	localparam logic [2:0] N_IDLE    = 3'd0;
	localparam logic [2:0] N_SHIFT   = 3'd1;
	localparam logic [2:0] N_SQ      = 3'd2;
	localparam logic [2:0] N_SQRT    = 3'd3;
	localparam logic [2:0] N_DIVGO   = 3'd4;
	localparam logic [2:0] N_DIVWAIT = 3'd5;

	logic [2:0]              state_q;
	logic                    done_q;
	logic [VEC_W-1:0]        a_q [3];
	logic [2:0]              neg_q;
	logic [1:0]              i_q;
	logic [SQ_W-1:0]         acc_q;
	logic [SQ_W-1:0]         x_q;
	logic [SQ_W-1:0]         r_q;
	logic [4:0]              k_q;
	logic signed [NRM_W-1:0] o_q [3];

	logic [VEC_W-1:0]        m;
	logic [2:0]              shamt;
	logic [2*RED_W-1:0]      sq;
	logic [SQ_W-1:0]         bitv;
	logic [SQ_W-1:0]         trial;
	logic [LEN_W-1:0]        len;
	logic [NRM_W-2:0]        q;
	div_req_t                dreq;
	div_rsp_t                drsp;

	mntg_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		m = a_q[0];
		if (a_q[1] > m) m = a_q[1];
		if (a_q[2] > m) m = a_q[2];
		shamt = '0;
		for (int j = RED_W; j < VEC_W; j++)
			if (m[j]) shamt = 3'(j - RED_W + 1);
	end

	assign sq    = a_q[i_q][RED_W-1:0] * a_q[i_q][RED_W-1:0];
	assign bitv  = SQ_W'(1) << {k_q, 1'b0};
	assign trial = r_q + bitv;
	assign len   = r_q[LEN_W-1:0];
	assign q     = drsp.quotient[NRM_W-2:0];

	assign dreq.start    = (state_q == N_DIVGO);
	assign dreq.dividend = (DIVD_W'(a_q[i_q][RED_W-1:0]) << UNIT_SHIFT) + DIVD_W'(len >> 1);
	assign dreq.divisor  = DVSR_W'(len);
	assign dreq.nbits    = NORM_QBITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				N_IDLE: begin
					if (req.start) state_q <= N_SHIFT;
				end
				N_SHIFT: begin
					if (m == '0) begin
						done_q  <= 1'b1;
						state_q <= N_IDLE;
					end else begin
						state_q <= N_SQ;
					end
				end
				N_SQ: begin
					if (i_q == 2'd2) state_q <= N_SQRT;
				end
				N_SQRT: begin
					if (k_q == '0) state_q <= N_DIVGO;
				end
				N_DIVGO: state_q <= N_DIVWAIT;
				N_DIVWAIT: begin
					if (drsp.done) begin
						if (i_q == 2'd2) begin
							done_q  <= 1'b1;
							state_q <= N_IDLE;
						end else begin
							state_q <= N_DIVGO;
						end
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			N_IDLE: begin
				if (req.start) begin
					a_q[0] <= mag_v(req.x);
					a_q[1] <= mag_v(req.y);
					a_q[2] <= mag_v(req.z);
					neg_q  <= {req.z[VEC_W-1], req.y[VEC_W-1], req.x[VEC_W-1]};
				end
			end
			N_SHIFT: begin
				if (m == '0) begin
					for (int i = 0; i < 3; i++) o_q[i] <= '0;
				end
				for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> shamt;
				i_q   <= '0;
				acc_q <= '0;
			end
			N_SQ: begin
				acc_q <= acc_q + SQ_W'(sq);
				if (i_q == 2'd2) begin
					x_q <= acc_q + SQ_W'(sq);
					r_q <= '0;
					k_q <= 5'd31;
				end else begin
					i_q <= i_q + 2'd1;
				end
			end
			N_SQRT: begin
				if (x_q >= trial) begin
					x_q <= x_q - trial;
					r_q <= (r_q >> 1) + bitv;
				end else begin
					r_q <= r_q >> 1;
				end
				k_q <= k_q - 5'd1;
				if (k_q == '0) i_q <= '0;
			end
			N_DIVWAIT: begin
				if (drsp.done) begin
					o_q[i_q] <= neg_q[i_q] ? -NRM_W'(q) : NRM_W'(q);
					if (i_q != 2'd2) i_q <= i_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.x    = o_q[0];
	assign rsp.y    = o_q[1];
	assign rsp.z    = o_q[2];

endmodule
`default_nettype wire

// File: hdl/mntg_chk.sv
// Port-level checker for the mesh normal block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mntg_chk import mntg_pkg::*; (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire logic [2:0]                opcode,
	input wire logic                      done,
	input wire logic signed [NRM_W-1:0]   normal_x,
	input wire logic signed [NRM_W-1:0]   normal_y,
	input wire logic signed [NRM_W-1:0]   normal_z,
	input wire logic signed [NRM_W-1:0]   tangent_x,
	input wire logic signed [NRM_W-1:0]   tangent_y,
	input wire logic signed [NRM_W-1:0]   tangent_z,
	input wire logic                      status
);

	// compute and clear both start a sweep of the sum memories
	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode == OP_COMPUTE || opcode == OP_CLEAR)) |=> busy)
		else $error("sweep did not raise busy");

	// loads leave busy low
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode == OP_LOAD_VERTEX || opcode == OP_LOAD_FACE)) |=> !busy)
		else $error("load held the block busy");

	a_unloaded_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0 &&
			tangent_x == '0 && tangent_y == '0 && tangent_z == '0))
		else $error("unloaded vertex returned nonzero vectors");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (normal_x >= -16'sd16384 && normal_x <= 16'sd16384 &&
			normal_y >= -16'sd16384 && normal_y <= 16'sd16384 &&
			normal_z >= -16'sd16384 && normal_z <= 16'sd16384))
		else $error("normal component out of Q1.14 unit range");

endmodule

bind mesh_normal_tangent_generator_core mntg_chk u_mntg_chk (.*);
`default_nettype wire
